>>> design/cnm_pkg.sv
package cnm_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_W     = 12;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // walk of the 3x3 grid (row-major, top-left first), clockwise and closed
  localparam int RING_ORDER [9] = '{0, 1, 2, 5, 8, 7, 6, 3, 0};

  typedef struct packed {
    logic       frame_done;
    logic [2:0] crossing_count;
    logic       is_minutia;
  } res_t;

  typedef struct packed {
    logic col_nz;
    logic col_first;
    logic col_last;
    logic row_last;
    logic upper;
    logic upper2;
  } pos_t;

  // column (top in bit 0) moved one row down with the bottom repeated
  function automatic logic [2:0] lower_col(logic [2:0] col);
    return {col[2], col[2], col[1]};
  endfunction

  function automatic res_t make_res(logic [2:0] l, logic [2:0] c, logic [2:0] r,
                                    logic done);
    logic [8:0] grid;
    logic [3:0] changes;
    logic [2:0] cn;
    res_t       res;
    grid    = {r[2], c[2], l[2], r[1], c[1], l[1], r[0], c[0], l[0]};
    changes = '0;
    for (int k = 0; k < 8; k++) begin
      changes = changes + {3'd0, grid[RING_ORDER[k]] ^ grid[RING_ORDER[k+1]]};
    end
    cn                 = changes[3:1];
    res.crossing_count = cn;
    res.is_minutia     = c[1] && (cn == 3'd1 || cn == 3'd3);
    res.frame_done     = done;
    return res;
  endfunction

endpackage

>>> design/crossing_number_minutiae_top.sv
// Crossing-number minutiae detector for a thinned binary image streamed in raster
// order, one pixel per word on the s_ side (tdata bit 0, 1 = ridge). Each pixel's
// 8-neighbour ring (borders replicate the edge pixels) gives a crossing number 0..4;
// a foreground pixel with crossing number 1 (ending) or 3 (bifurcation) is flagged.
// Results for a row come out while the next row streams in; the last row is
// finished alongside the row above it, so a frame needs no trailing input. A pixel
// yields 0 to 4 result words; tlast marks the last word caused by that pixel and
// tuser marks the frame's last pixel. Rate: one pixel per clock as long as each
// pixel yields at most one word and m_tready stays high; a pixel yielding k words
// (up to 4 at the last column of the last row) holds the single output register
// until its last word is taken, so a following pixel that also yields words waits
// and the input stalls with it. The first word caused by a pixel passes the stage-1
// register and then the output register. Two bits of row history per column
// live in a 1024 x 2 RAM with one read and one write port; read-after-write on the
// same column (one-pixel rows) is forwarded. The RAM is not cleared after reset; the
// top row of a frame never reads it and the second row reads only the bit written
// by the top row. Sizes: image_width (index 0, 0 acts as 1, capped at 1024) and
// image_height (index 1, 0 acts as 1), both 512 after reset; write them only while
// idle.
module crossing_number_minutiae_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] pixel_value, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] is_minutia, [3:1] crossing_count, [7:4] zero
  output logic        m_tlast,   // run_last
  output logic        m_tuser,   // [0] frame_done
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [cnm_pkg::CFG_W-1:0] cfg_data
);
  import cnm_pkg::*;

  // configuration
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(512);
      image_height <= HEIGHT_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes and position flags of the incoming pixel
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    column_index;
  logic [HEIGHT_W-1:0] row_index;
  pos_t                pos;
  logic                accept;
  logic                s1_fire;
  logic                s1_valid;

  always_comb begin
    if (image_width == '0) w_eff = WIDTH_W'(1);
    else if (image_width > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
    else w_eff = image_width;
    h_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;

    pos.col_nz    = column_index != '0;
    pos.col_first = column_index == '0;
    pos.col_last  = ({1'b0, column_index} + WIDTH_W'(1)) >= w_eff;
    pos.row_last  = ({1'b0, row_index} + 13'd1) >= {1'b0, h_eff};
    pos.upper     = row_index >= HEIGHT_W'(1);
    pos.upper2    = row_index >= HEIGHT_W'(2);
  end

  assign s_tready = !s1_valid || s1_fire;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
    end else if (accept) begin
      if (pos.col_last) begin
        column_index <= '0;
        row_index    <= pos.row_last ? '0 : row_index + HEIGHT_W'(1);
      end else begin
        column_index <= column_index + COL_W'(1);
      end
    end
  end

  // row history RAM: bit 0 previous row, bit 1 the row before it
  logic [1:0]       row_store [MAX_WIDTH];
  logic [1:0]       mem_q;
  logic [1:0]       wr_data;
  logic [COL_W-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (s1_fire) row_store[s1_col] <= wr_data;
    if (accept)  mem_q <= row_store[column_index];
  end

  // stage 1: pixel waiting for its history word
  logic       s1_pix;
  pos_t       s1_pos;
  logic       s1_byp;
  logic [1:0] s1_byp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= s_tdata[0];
      s1_col      <= column_index;
      s1_pos      <= pos;
      // same column written back on this edge: the RAM read returns stale data
      s1_byp      <= s1_fire && (s1_col == column_index);
      s1_byp_data <= wr_data;
    end
  end

  // history merge, window shift and the four candidate results
  logic [8:0] window_bits;
  logic [8:0] win_next;
  logic [1:0] hist;
  logic       rb, ra;
  logic [2:0] up, l, c, r;
  res_t       cand [4];
  logic [3:0] cand_mask;

  always_comb begin
    hist     = s1_byp ? s1_byp_data : mem_q;
    rb       = s1_pos.upper  ? hist[0] : s1_pix;
    ra       = s1_pos.upper2 ? hist[1] : rb;
    wr_data  = {rb, s1_pix};
    up       = {s1_pix, rb, ra};
    win_next = s1_pos.col_first ? {up, up, up} : {up, window_bits[8:3]};
    l        = win_next[2:0];
    c        = win_next[5:3];
    r        = win_next[8:6];

    // pixel one column back, then the last-column pixel, each for the row above
    // and (on the last row) for the current row
    cand[0] = make_res(l, c, r, 1'b0);
    cand[1] = make_res(lower_col(l), lower_col(c), lower_col(r), 1'b0);
    cand[2] = make_res(c, r, r, 1'b0);
    cand[3] = make_res(lower_col(c), lower_col(r), lower_col(r), 1'b1);
    cand_mask = {s1_pos.col_last & s1_pos.row_last,
                 s1_pos.col_last & s1_pos.upper,
                 s1_pos.col_nz   & s1_pos.row_last,
                 s1_pos.col_nz   & s1_pos.upper};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (s1_fire) begin
      window_bits <= win_next;
    end
  end

  // output register: up to four pending words, sent lowest first
  res_t       ent [4];
  logic [3:0] ent_mask;
  logic [3:0] rest_mask;
  logic [1:0] sel;
  logic       out_hs;
  logic       out_last;

  always_comb begin
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (ent_mask[i]) sel = 2'(i);
    end
    rest_mask = ent_mask & (ent_mask - 4'd1);
    out_last  = rest_mask == '0;
  end

  assign m_tvalid = ent_mask != '0;
  assign m_tdata  = {4'd0, ent[sel].crossing_count, ent[sel].is_minutia};
  assign m_tlast  = out_last;
  assign m_tuser  = ent[sel].frame_done;
  assign out_hs   = m_tvalid && m_tready;

  assign s1_fire = s1_valid && (cand_mask == '0 || ent_mask == '0 || (out_hs && out_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_mask <= '0;
    end else if (s1_fire && cand_mask != '0) begin
      ent_mask <= cand_mask;
    end else if (out_hs) begin
      ent_mask <= rest_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && cand_mask != '0) begin
      for (int i = 0; i < 4; i++) ent[i] <= cand[i];
    end
  end

  // checks
  frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_done word is not the last word of its pixel");

  count_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:1] <= 3'd4)
    else $error("crossing count above four");

  minutia_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[3:1] == 3'd1 || m_tdata[3:1] == 3'd3))
    else $error("minutia flagged with crossing count other than one or three");

  stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_col) && $stable(s1_pix))
    else $error("stalled pixel lost or changed before its results were queued");

endmodule

>>> bench/tb_crossing_number_minutiae_top.sv
`timescale 1ns / 1ps

module tb_crossing_number_minutiae_top;
  import cnm_pkg::*;

  // one expected result word as the block should send it
  typedef struct packed {
    logic       is_minutia;
    logic [2:0] crossing_count;
    logic       frame_done;
    logic       run_last;
  } minutia_word_t;

  // predicts the result words of each accepted pixel and checks them in order
  class minutia_scoreboard;
    logic [1:0]    row_hist [MAX_WIDTH];   // bit 0 previous row, bit 1 the row above it
    logic [8:0]    window;                 // left, centre, right columns, top in low bit
    int unsigned   row_idx;
    int unsigned   col_idx;
    logic [10:0]   width_reg;
    logic [11:0]   height_reg;
    minutia_word_t expected_words [$];
    int            mismatches;
    int            words_seen;

    function new();
      for (int k = 0; k < MAX_WIDTH; k++) row_hist[k] = 2'b00;
      window     = '0;
      row_idx    = 0;
      col_idx    = 0;
      width_reg  = 11'd512;
      height_reg = 12'd512;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void set_size(logic idx, logic [11:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val[10:0];
      else height_reg = val;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // column shifted one row down, bottom pixel repeated
    function logic [2:0] drop_row(logic [2:0] column);
      return {column[2], column[2], column[1]};
    endfunction

    // crossing number of the ring around the centre of a 3x3 window
    function minutia_word_t judge(logic [2:0] l, logic [2:0] c, logic [2:0] r, logic done);
      logic [7:0]    ring;
      logic [2:0]    cn;
      minutia_word_t w;
      // clockwise from top-left: tl, t, tr, r, br, b, bl, l
      ring = {l[1], l[2], c[2], r[2], r[1], r[0], c[0], l[0]};
      cn = 3'($countones(ring ^ {ring[0], ring[7:1]}) >> 1);
      w.is_minutia     = c[1] && (cn == 3'd1 || cn == 3'd3);
      w.crossing_count = cn;
      w.frame_done     = done;
      w.run_last       = 1'b0;
      return w;
    endfunction

    function void note_pixel(logic pix);
      int unsigned   w, h, col;
      logic          lastc, lastr, upper, ra, rb;
      logic [1:0]    hist;
      logic [2:0]    up, l, c, r;
      minutia_word_t batch [4];
      int            n;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      col = (col_idx >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_idx;
      lastc = (col + 1 >= w);
      lastr = (row_idx + 1 >= h);
      upper = (row_idx >= 1);
      hist = row_hist[col];
      rb = upper ? hist[0] : pix;
      ra = (row_idx >= 2) ? hist[1] : rb;
      row_hist[col] = {rb, pix};
      up = {pix, rb, ra};
      window = (col == 0) ? {up, up, up} : {up, window[8:3]};
      l = window[2:0];
      c = window[5:3];
      r = window[8:6];
      n = 0;
      if (col >= 1) begin
        if (upper) begin
          batch[n] = judge(l, c, r, 1'b0);
          n++;
        end
        if (lastr) begin
          batch[n] = judge(drop_row(l), drop_row(c), drop_row(r), 1'b0);
          n++;
        end
      end
      if (lastc) begin
        if (upper) begin
          batch[n] = judge(c, r, r, 1'b0);
          n++;
        end
        if (lastr) begin
          batch[n] = judge(drop_row(c), drop_row(r), drop_row(r), 1'b1);
          n++;
        end
      end
      if (n > 0) batch[n-1].run_last = 1'b1;
      for (int k = 0; k < n; k++) expected_words.push_back(batch[k]);
      if (lastc) begin
        col_idx = 0;
        row_idx = lastr ? 0 : ((row_idx + 1) & 12'hFFF);
      end else begin
        col_idx = col + 1;
      end
    endfunction

    function void check_word(logic [7:0] data, logic last, logic done_flag);
      minutia_word_t want;
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d arrived with nothing expected: data=%02h last=%0b done=%0b",
                   words_seen, data, last, done_flag);
        return;
      end
      want = expected_words.pop_front();
      if (data !== {4'd0, want.crossing_count, want.is_minutia} ||
          last !== want.run_last || done_flag !== want.frame_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"word %0d mismatch: expected minutia=%0b count=%0d done=%0b last=%0b,",
                    " got data=%02h done=%0b last=%0b"},
                   words_seen, want.is_minutia, want.crossing_count, want.frame_done,
                   want.run_last, data, done_flag, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_data;

  minutia_scoreboard sb = new();

  int burst_left  = 0;  // pixels left in the current sender burst
  int pixels_sent = 0;
  bit held_off    = 0;  // long receiver hold-off already done

  crossing_number_minutiae_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one pixel and wait for it to be taken; bursts with random gaps in between
  task automatic send_pixel(input logic pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tdata  <= {7'd0, pix};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(pix);
    pixels_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // stop offering, wait for every expected word, then let the pipeline settle
  task automatic drain_to_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_size(input logic idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_size(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one whole frame of random pixels at the given raw register values
  task automatic run_frame(input logic [11:0] w_raw, input logic [11:0] h_raw,
                           input int density);
    int eff_w;
    int eff_h;
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, w_raw);
    write_size(REG_IMAGE_HEIGHT, h_raw);
    eff_w = w_raw[10:0];
    if (eff_w == 0) eff_w = 1;
    if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
    eff_h = (h_raw == 0) ? 1 : h_raw;
    for (int k = 0; k < eff_w * eff_h; k++)
      send_pixel($urandom_range(0, 99) < density);
  endtask

  // compare every word taken on the result side
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
    end
  end

  // receiver back-pressure: stall modes picked at random in turn, plus one long hold-off
  initial begin
    int mode;
    int age;
    m_tready = 1'b0;
    mode = 0;
    age  = 0;
    forever begin
      @(negedge clk);
      if (!held_off && sb.words_seen >= 100 && s_tvalid) begin
        // hold off long enough that the block fills and stalls its input
        held_off = 1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (age == 0) mode = $urandom_range(0, 2);
      age = (age + 1) % 64;
      case (mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // main sequence
  initial begin
    logic [8:0] cross_pattern;
    int         random_goal;
    int         w_raw;
    int         h_raw;
    int         settle;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = 12'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero sizes act as a one-pixel frame: a ridge pixel, then a background one
    write_size(REG_IMAGE_WIDTH, 12'd0);
    write_size(REG_IMAGE_HEIGHT, 12'd0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // smallest nominal frame, all foreground (every neighbour replicated)
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'd2);
    write_size(REG_IMAGE_HEIGHT, 12'd2);
    repeat (4) send_pixel(1'b1);

    // corners set, edges clear: crossing number four at the centre
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'd3);
    write_size(REG_IMAGE_HEIGHT, 12'd3);
    cross_pattern = 9'b101_010_101;
    for (int k = 0; k < 9; k++) send_pixel(cross_pattern[k]);

    // sizes shrunk mid-frame: position lands past the new last column, on the last row
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'd4);
    write_size(REG_IMAGE_HEIGHT, 12'd4);
    repeat (6) send_pixel(1'($urandom_range(0, 1)));
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'd2);
    write_size(REG_IMAGE_HEIGHT, 12'd2);
    send_pixel(1'($urandom_range(0, 1)));

    // all size bits set (width capped): a few pixels of the top row, then cut short
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'hFFF);
    write_size(REG_IMAGE_HEIGHT, 12'hFFF);
    repeat (8) send_pixel(1'($urandom_range(0, 1)));
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'd2);
    write_size(REG_IMAGE_HEIGHT, 12'd1);
    send_pixel(1'($urandom_range(0, 1)));

    // one-column frame of maximum height, stopped by a height shrink
    drain_to_idle();
    write_size(REG_IMAGE_WIDTH, 12'd1);
    write_size(REG_IMAGE_HEIGHT, 12'hFFF);
    repeat (40) send_pixel(1'($urandom_range(0, 1)));
    drain_to_idle();
    write_size(REG_IMAGE_HEIGHT, 12'd2);
    send_pixel(1'($urandom_range(0, 1)));

    // random frames, mostly narrow, now and then wider
    random_goal = pixels_sent + 300;
    while (pixels_sent < random_goal) begin
      w_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      h_raw = $urandom_range(0, 7);
      run_frame(12'(w_raw), 12'(h_raw), $urandom_range(10, 70));
    end

    // wait out the last words with a bound
    s_tvalid <= 1'b0;
    settle = 0;
    while (sb.pending() > 0 && settle < 100000) begin
      @(negedge clk);
      settle++;
    end
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
